// ===== src/rrc_pkg.sv =====
// shared constants, types and helper functions of the random replacement cache
`timescale 1ns / 1ps

package rrc_pkg;

    localparam int MAX_SLOTS  = 64;
    localparam int SLOT_AW    = $clog2(MAX_SLOTS);
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int CAP_W      = 7;
    localparam int SEED_W     = 32;
    localparam int ID_W       = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [SEED_W-1:0] LFSR_MASK = 32'h8020_0003;

    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [SLOT_AW-1:0] t_slot;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 1'b0,
        CFG_SEED     = 1'b1
    } t_cfg_idx;

    // capacity in use: zero acts as one, saturates at the slot count
    function automatic t_cnt eff_cap(input logic [CAP_W-1:0] cap);
        logic [31:0] c;
        c = 32'(cap);
        if (c == 32'd0) begin
            c = 32'd1;
        end
        if (c > 32'(MAX_SLOTS)) begin
            c = 32'(MAX_SLOTS);
        end
        return CNT_W'(c);
    endfunction

    // one step of the right-shifting galois lfsr
    function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_MASK;
        end
        return s;
    endfunction

endpackage

// ===== src/rrc_rem.sv =====
// bit-serial restoring remainder unit: random value modulo capacity
`timescale 1ns / 1ps

module rrc_rem import rrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SEED_W-1:0] i_dividend,
    input  t_cnt              i_divisor,
    output logic              o_done,
    output t_slot             o_rem
);

    localparam int RCNT_W = $clog2(SEED_W);
    localparam logic [RCNT_W-1:0] LAST_STEP = RCNT_W'(SEED_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [RCNT_W-1:0] r_cnt;
    logic [SEED_W-1:0] r_q;
    t_cnt              r_rem;
    t_cnt              r_div;

    logic [CNT_W:0]    w_shifted;
    logic [CNT_W:0]    w_diff;
    t_cnt              n_rem;

    always_comb begin
        w_shifted = {r_rem, r_q[SEED_W-1]};
        w_diff    = w_shifted - {1'b0, r_div};
        if (w_shifted >= {1'b0, r_div}) begin
            n_rem = w_diff[CNT_W-1:0];
        end else begin
            n_rem = w_shifted[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + RCNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= r_q << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[SLOT_AW-1:0];

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a running division");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !$past(i_start)) |-> (r_cnt == '0))
        else $error("step counter moved while idle");

endmodule

// ===== src/random_replacement_cache.sv =====
// top level of the random replacement cache: sequencer, slot memory and lfsr
`timescale 1ns / 1ps

// Fully associative store of up to MAX_SLOTS (64) 64-bit chunk identifiers.
// One beat on the input channel is a lookup (req_type 0) or a store
// (req_type 1); each gives exactly one result beat with hit, is_full and,
// for a store that misses in a full cache, the evicted identifier. The slots sit in a
// single-port-read memory, so a request is checked against the held
// identifiers by scanning them one slot per cycle with a single comparator.
// The scan stops at the first match or at the occupancy; a store that misses
// in a full cache then runs the bit-serial remainder of the lfsr value by the
// capacity, which picks the victim, and reads and overwrites that victim.
// o_stall is high from the accepted input beat until the result beat is
// placed in the output register; the output register lets a new input beat
// enter while the previous result still waits. The capacity register (index
// 0) takes effect on the next item: zero acts as one, values above 64 act as
// 64, and lowering it below the occupancy drops the upper slots. Writing the
// seed register (index 1) reloads the lfsr at once, zero loading as one.
// The user must write configuration only while no item is in flight (unenforced).
// The slot memory needs no clearing: only slots below the occupancy are ever used.

module random_replacement_cache import rrc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_req_type,
    input  logic [ID_W-1:0]       i_chunk_id,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_hit,
    output logic                  o_is_full,
    output logic                  o_evicted_valid,
    output logic [ID_W-1:0]       o_evicted_chunk
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_MOD    = 6'b001000,
        S_EVRD   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    // sequencer and item registers
    t_state            r_state, n_state;
    logic              r_req,   n_req;
    logic [ID_W-1:0]   r_id,    n_id;
    t_slot             r_idx,   n_idx;
    logic              r_hit,   n_hit;
    logic              r_ev_valid, n_ev_valid;
    logic [ID_W-1:0]   r_ev_chunk, n_ev_chunk;
    t_slot             r_victim, n_victim;

    // architectural state
    t_cnt              r_occ,  n_occ;
    logic [CAP_W-1:0]  r_cap;
    logic [SEED_W-1:0] r_lfsr, n_lfsr;

    // output register
    logic              r_out_valid;
    logic              r_out_hit;
    logic              r_out_full;
    logic              r_out_ev_valid;
    logic [ID_W-1:0]   r_out_ev_chunk;

    // slot memory
    logic [ID_W-1:0]   r_slot_mem [MAX_SLOTS];
    logic [ID_W-1:0]   r_rdata;
    logic              w_rd_en;
    t_slot             w_rd_addr;
    logic              w_wr_en;
    t_slot             w_wr_addr;

    // remainder unit
    logic              w_rem_start;
    logic              w_rem_done;
    t_slot             w_rem;

    t_cnt              w_cap;
    t_cnt              w_cfg_cap;
    logic              w_in_beat;
    logic              w_out_free;
    logic              w_out_load;
    logic              w_scan_last;

    assign w_cap      = eff_cap(r_cap);
    assign w_cfg_cap  = eff_cap(i_cfg_data[CAP_W-1:0]);
    assign o_stall    = (r_state != S_IDLE);
    assign w_in_beat  = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_scan_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_occ);

    rrc_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (r_lfsr),
        .i_divisor  (w_cap),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_id        = r_id;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_ev_valid  = r_ev_valid;
        n_ev_chunk  = r_ev_chunk;
        n_victim    = r_victim;
        n_occ       = r_occ;
        n_lfsr      = r_lfsr;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_victim;
        w_rem_start = 1'b0;
        w_out_load  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_req      = i_req_type;
                    n_id       = i_chunk_id;
                    n_idx      = '0;
                    n_hit      = 1'b0;
                    n_ev_valid = 1'b0;
                    n_ev_chunk = '0;
                    // first slot read goes out with the accepted beat
                    w_rd_en    = 1'b1;
                    w_rd_addr  = '0;
                    if (r_occ == '0) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // r_rdata holds slot r_idx
                if (r_rdata == r_id) begin
                    n_hit   = 1'b1;
                    n_state = S_DECIDE;
                end else if (w_scan_last) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx     = r_idx + SLOT_AW'(1);
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_idx + SLOT_AW'(1);
                end
            end
            S_DECIDE: begin
                if (r_req && !r_hit) begin
                    if (r_occ < w_cap) begin
                        // append to the next free slot
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_occ[SLOT_AW-1:0];
                        n_occ     = r_occ + CNT_W'(1);
                        n_state   = S_DONE;
                    end else begin
                        w_rem_start = 1'b1;
                        n_state     = S_MOD;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MOD: begin
                if (w_rem_done) begin
                    n_victim  = w_rem;
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_rem;
                    n_state   = S_EVRD;
                end
            end
            S_EVRD: begin
                // victim contents are out, overwrite and step the lfsr
                n_ev_valid = 1'b1;
                n_ev_chunk = r_rdata;
                w_wr_en    = 1'b1;
                w_wr_addr  = r_victim;
                n_lfsr     = lfsr_next(r_lfsr);
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // the user must write configuration only while idle; the block does not check
        if (i_cfg_we) begin
            if (i_cfg_index == CFG_CAPACITY) begin
                if (r_occ > w_cfg_cap) begin
                    n_occ = w_cfg_cap;
                end
            end else if (i_cfg_index == CFG_SEED) begin
                if (i_cfg_data[SEED_W-1:0] == '0) begin
                    n_lfsr = SEED_W'(1);
                end else begin
                    n_lfsr = i_cfg_data[SEED_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_cap       <= CAP_W'(64);
            r_lfsr      <= SEED_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_lfsr  <= n_lfsr;
            if (i_cfg_we && (i_cfg_index == CFG_CAPACITY)) begin
                r_cap <= i_cfg_data[CAP_W-1:0];
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_id       <= n_id;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_ev_valid <= n_ev_valid;
        r_ev_chunk <= n_ev_chunk;
        r_victim   <= n_victim;
        if (w_out_load) begin
            r_out_hit      <= r_hit;
            r_out_full     <= (r_occ == w_cap);
            r_out_ev_valid <= r_ev_valid;
            r_out_ev_chunk <= r_ev_chunk;
        end
    end

    // slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_slot_mem[w_wr_addr] <= r_id;
        end
        if (w_rd_en) begin
            r_rdata <= r_slot_mem[w_rd_addr];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_is_full       = r_out_full;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_chunk = r_out_ev_chunk;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= w_cap)
        else $error("occupancy above capacity");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ev_valid) |-> (r_out_full && !r_out_hit))
        else $error("eviction reported without a full miss");

    a_lfsr_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0)
        else $error("lfsr locked at zero");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_idx) < r_occ))
        else $error("scan beyond occupied slots");

endmodule
